>>> rtl/core/http_header_field_tokenizer_core_defines.svh
// Assertion macros used by the checker file.
`ifndef HTTP_HEADER_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define HTTP_HEADER_FIELD_TOKENIZER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HHFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define HHFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hhft_pkg.sv
`default_nettype none
package hhft_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        CMD_DATA    = 2'd0,
        CMD_EOI     = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        K_NAME  = 3'd0,
        K_VALUE = 3'd1,
        K_END   = 3'd2,
        K_DONE  = 3'd3,
        K_ERR   = 3'd4
    } kind_t;

    // Results caused by one input word: one or two tokens.
    typedef struct packed {
        logic       two;
        kind_t      k0;
        logic [7:0] d0;
        kind_t      k1;
        logic [7:0] d1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/hhft_if.sv
`default_nettype none
interface hhft_byte_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data;

    modport source (output valid, output cmd, output data, input ready);
    modport sink (input valid, input cmd, input data, output ready);
endinterface

interface hhft_tok_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_res;
    logic       last;

    modport source (output valid, output kind, output data_res, output last, input ready);
    modport sink (input valid, input kind, input data_res, input last, output ready);
endinterface

interface hhft_cfg_if;
    logic valid;
    logic ready;
    logic fold_enable;

    modport source (output valid, output fold_enable, input ready);
    modport sink (input valid, input fold_enable, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hhft_front.sv
`default_nettype none
module hhft_front (
    input  logic               clk,
    input  logic               rst_n,
    hhft_byte_if.sink          byte_ch,
    hhft_cfg_if.sink           cfg_ch,
    input  hhft_pkg::fifo_stat_t q_stat,
    output logic               job_push,
    output hhft_pkg::job_t     job
);
    import hhft_pkg::*;

    typedef enum logic [11:0] {
        M_LINE   = 12'b0000_0000_0001,
        M_NAME   = 12'b0000_0000_0010,
        M_SKIPSP = 12'b0000_0000_0100,
        M_VALUE  = 12'b0000_0000_1000,
        M_DROP   = 12'b0000_0001_0000,
        M_QUOTED = 12'b0000_0010_0000,
        M_QESC   = 12'b0000_0100_0000,
        M_QSKIP  = 12'b0000_1000_0000,
        M_FOLD   = 12'b0001_0000_0000,
        M_BLANK  = 12'b0010_0000_0000,
        M_DONE   = 12'b0100_0000_0000,
        M_ERROR  = 12'b1000_0000_0000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       open_reg, open_next;
    logic       fold_reg;
    logic       has_res;
    logic       accept;
    logic [7:0] c;
    logic       is_cr, is_lf, ws;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || ((b >= CH_HT) && (b <= CH_CR));
    endfunction

    assign cfg_ch.ready  = 1'b1;
    assign byte_ch.ready = !q_stat.full;
    assign accept        = byte_ch.valid && !q_stat.full;
    assign job_push      = accept && has_res;

    assign c     = byte_ch.data;
    assign is_cr = (c == CH_CR);
    assign is_lf = (c == CH_LF);
    assign ws    = is_ws(c);

    always_comb
    begin
        mode_next = mode_reg;
        open_next = open_reg;
        has_res   = 1'b0;
        job.two   = 1'b0;
        job.k0    = K_NAME;
        job.d0    = 8'd0;
        job.k1    = K_NAME;
        job.d1    = 8'd0;
        unique case (cmd_t'(byte_ch.cmd))
            CMD_DATA:
            begin
                unique case (mode_reg)
                    M_LINE:
                    begin
                        if (is_cr)
                        begin
                            has_res   = open_reg;
                            job.k0    = K_END;
                            open_next = 1'b0;
                            mode_next = M_BLANK;
                        end
                        else if (ws)
                        begin
                            if (!fold_reg || !open_reg)
                            begin
                                has_res   = 1'b1;
                                job.k0    = K_ERR;
                                mode_next = M_ERROR;
                            end
                            else
                            begin
                                mode_next = M_FOLD;
                            end
                        end
                        else
                        begin
                            // close the pending field before the new name
                            open_next = 1'b0;
                            if (c == CH_COLON)
                            begin
                                has_res   = open_reg;
                                job.k0    = K_END;
                                mode_next = M_SKIPSP;
                            end
                            else
                            begin
                                has_res   = 1'b1;
                                mode_next = M_NAME;
                                if (open_reg)
                                begin
                                    job.two = 1'b1;
                                    job.k0  = K_END;
                                    job.k1  = K_NAME;
                                    job.d1  = c;
                                end
                                else
                                begin
                                    job.k0 = K_NAME;
                                    job.d0 = c;
                                end
                            end
                        end
                    end
                    M_NAME:
                    begin
                        if (is_cr)
                        begin
                            has_res   = 1'b1;
                            job.k0    = K_ERR;
                            mode_next = M_ERROR;
                        end
                        else if (c == CH_COLON)
                        begin
                            mode_next = M_SKIPSP;
                        end
                        else
                        begin
                            has_res = 1'b1;
                            job.k0  = K_NAME;
                            job.d0  = c;
                        end
                    end
                    M_SKIPSP:
                    begin
                        if (is_cr)
                        begin
                            has_res   = 1'b1;
                            job.k0    = K_ERR;
                            mode_next = M_ERROR;
                        end
                        else if (ws)
                        begin
                            mode_next = M_SKIPSP;
                        end
                        else if (c == CH_QUOTE)
                        begin
                            mode_next = M_QUOTED;
                        end
                        else
                        begin
                            has_res   = 1'b1;
                            job.k0    = K_VALUE;
                            job.d0    = c;
                            mode_next = M_VALUE;
                        end
                    end
                    M_FOLD:
                    begin
                        if (is_cr)
                        begin
                            has_res   = 1'b1;
                            job.k0    = K_ERR;
                            mode_next = M_ERROR;
                        end
                        else if (!ws)
                        begin
                            // folded line: a space, then the first byte
                            has_res   = 1'b1;
                            job.two   = 1'b1;
                            job.k0    = K_VALUE;
                            job.d0    = CH_SP;
                            job.k1    = K_VALUE;
                            job.d1    = c;
                            mode_next = M_VALUE;
                        end
                    end
                    M_VALUE:
                    begin
                        if (is_cr)
                        begin
                            mode_next = M_DROP;
                        end
                        else
                        begin
                            has_res = 1'b1;
                            job.k0  = K_VALUE;
                            job.d0  = c;
                        end
                    end
                    M_DROP:
                    begin
                        open_next = 1'b1;
                        mode_next = M_LINE;
                    end
                    M_QUOTED:
                    begin
                        if (is_cr || is_lf)
                        begin
                            has_res   = 1'b1;
                            job.k0    = K_ERR;
                            mode_next = M_ERROR;
                        end
                        else if (c == CH_BSL)
                        begin
                            mode_next = M_QESC;
                        end
                        else if (c == CH_QUOTE)
                        begin
                            mode_next = M_QSKIP;
                        end
                        else
                        begin
                            has_res = 1'b1;
                            job.k0  = K_VALUE;
                            job.d0  = c;
                        end
                    end
                    M_QESC:
                    begin
                        has_res = 1'b1;
                        if (is_cr || is_lf)
                        begin
                            job.k0    = K_ERR;
                            mode_next = M_ERROR;
                        end
                        else
                        begin
                            job.k0    = K_VALUE;
                            job.d0    = c;
                            mode_next = M_QUOTED;
                        end
                    end
                    M_QSKIP:
                    begin
                        if (is_lf)
                        begin
                            open_next = 1'b1;
                            mode_next = M_LINE;
                        end
                    end
                    M_BLANK:
                    begin
                        if (is_lf)
                        begin
                            has_res   = 1'b1;
                            job.k0    = K_DONE;
                            mode_next = M_DONE;
                        end
                    end
                    M_DONE:
                    begin
                        mode_next = M_DONE;
                    end
                    default:
                    begin
                        mode_next = M_ERROR;
                    end
                endcase
            end
            CMD_EOI:
            begin
                if (mode_reg != M_DONE && mode_reg != M_ERROR)
                begin
                    has_res   = 1'b1;
                    job.k0    = K_ERR;
                    mode_next = M_ERROR;
                end
            end
            CMD_RESTART:
            begin
                mode_next = M_LINE;
                open_next = 1'b0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_LINE;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            fold_reg <= cfg_ch.fold_enable;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/hhft_fifo.sv
`default_nettype none
module hhft_fifo #(
    parameter int unsigned DEPTH = hhft_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hhft_pkg::job_t       wr_job,
    input  logic                 pop,
    output hhft_pkg::job_t       rd_job,
    output hhft_pkg::fifo_stat_t stat
);
    import hhft_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/hhft_back.sv
`default_nettype none
module hhft_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hhft_pkg::fifo_stat_t q_stat,
    input  hhft_pkg::job_t       q_rd,
    output logic                 q_pop,
    hhft_tok_if.source           tok_ch
);
    import hhft_pkg::*;

    logic       out_valid_reg, out_valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       sec_valid_reg, sec_valid_next;
    kind_t      sec_kind_reg, sec_kind_next;
    logic [7:0] sec_data_reg, sec_data_next;
    logic       load;

    // output slot is free or its word leaves this cycle
    assign load  = !out_valid_reg || tok_ch.ready;
    assign q_pop = load && !sec_valid_reg && !q_stat.empty;

    assign tok_ch.valid    = out_valid_reg;
    assign tok_ch.kind     = kind_reg;
    assign tok_ch.data_res = data_reg;
    assign tok_ch.last     = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        sec_valid_next = sec_valid_reg;
        sec_kind_next  = sec_kind_reg;
        sec_data_next  = sec_data_reg;
        if (load)
        begin
            if (sec_valid_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = sec_kind_reg;
                data_next      = sec_data_reg;
                last_next      = 1'b1;
                sec_valid_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                out_valid_next = 1'b1;
                kind_next      = q_rd.k0;
                data_next      = q_rd.d0;
                last_next      = !q_rd.two;
                // hold the second token until the first is taken
                sec_valid_next = q_rd.two;
                sec_kind_next  = q_rd.k1;
                sec_data_next  = q_rd.d1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        sec_kind_reg <= sec_kind_next;
        sec_data_reg <= sec_data_next;
    end

endmodule
`default_nettype wire

>>> rtl/core/http_header_field_tokenizer_core.sv
// The first token word of a byte passes the queue, then the back end's output register.
// Throughput: one input byte per cycle while the queue is not full; one token word per cycle
// leaves the back end while tok_ch is ready, so a byte that gives two tokens occupies two words.
// A queue of QUEUE_DEPTH entries between front and back absorbs output stalls.
// Reset: parser returns to line start, fold_enable clears to 0, queue empties.
`default_nettype none
module http_header_field_tokenizer_core #(
    parameter int unsigned QUEUE_DEPTH = hhft_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hhft_byte_if.sink  byte_ch,
    hhft_tok_if.source tok_ch,
    hhft_cfg_if.sink   cfg_ch
);
    import hhft_pkg::*;

    job_t       push_job;
    job_t       rd_job;
    fifo_stat_t q_stat;
    logic       push;
    logic       pop;

    hhft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .cfg_ch   (cfg_ch),
        .q_stat   (q_stat),
        .job_push (push),
        .job      (push_job)
    );

    hhft_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .pop    (pop),
        .rd_job (rd_job),
        .stat   (q_stat)
    );

    hhft_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_rd   (rd_job),
        .q_pop  (pop),
        .tok_ch (tok_ch)
    );

endmodule
`default_nettype wire

>>> rtl/core/hhft_checker.sv
`default_nettype none
`include "http_header_field_tokenizer_core_defines.svh"
module hhft_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic [7:0] data_res,
    input logic       last
);
    import hhft_pkg::*;

    `HHFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_res) && $stable(last), "stalled token word changed")
    `HHFT_ASSERT(a_marker_zero, !(out_valid && kind != K_NAME && kind != K_VALUE) || (data_res == 8'd0), "marker word carries a nonzero byte")
    `HHFT_ASSERT(a_err_done_last, !(out_valid && (kind == K_ERR || kind == K_DONE)) || last, "error or done word not marked last")

endmodule

bind http_header_field_tokenizer_core hhft_checker u_hhft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (tok_ch.valid),
    .out_ready (tok_ch.ready),
    .kind      (tok_ch.kind),
    .data_res  (tok_ch.data_res),
    .last      (tok_ch.last)
);
`default_nettype wire
